>>> rtl/sp_cc_pkg.sv
`timescale 1ns / 1ps

package sp_cc_pkg;

  // Width of totals and peaks, and of the threshold and watermark.
  localparam int unsigned ValueWidth = 48;
  localparam int unsigned WmWidth    = 47;
  // Compare width that holds a non-negative value and the threshold alike.
  localparam int unsigned CmpWidth   =
      ((ValueWidth > WmWidth) ? ValueWidth : WmWidth) + 1;

  typedef logic signed [ValueWidth-1:0] val_t;
  typedef logic [WmWidth-1:0]           wm_t;
  typedef logic [CmpWidth-1:0]          cmp_t;

  localparam val_t ValMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam val_t ValMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam wm_t  WmMax  = {WmWidth{1'b1}};

  // Combine codes carried by req_type.
  localparam logic ReqSeries   = 1'b0;
  localparam logic ReqParallel = 1'b1;

  typedef struct packed {
    logic req_type;
    val_t left_total;
    val_t left_single;
    val_t left_robust;
    logic left_robust_valid;
    logic left_trivial;
    val_t right_total;
    val_t right_single;
    val_t right_robust;
    logic right_robust_valid;
    logic right_trivial;
  } req_t;

  typedef struct packed {
    val_t out_total;
    val_t out_single;
    val_t out_robust;
    logic out_robust_valid;
    logic out_trivial;
    wm_t  watermark;
  } rsp_t;

  // Optional value; the value is kept at zero whenever it is null.
  typedef struct packed {
    val_t v;
    logic ok;
  } opt_t;

  typedef struct packed {
    val_t total;
    val_t single;
    opt_t robust;
    logic trivial;
  } summ_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [ValueWidth:0] s;
    val_t r;
    s = {a[ValueWidth-1], a} + {b[ValueWidth-1], b};
    if (s[ValueWidth] != s[ValueWidth-1]) begin
      r = s[ValueWidth] ? ValMin : ValMax;
    end else begin
      r = s[ValueWidth-1:0];
    end
    return r;
  endfunction

  function automatic val_t vmax(val_t a, val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic opt_t some(val_t v);
    opt_t r;
    r.v  = v;
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic opt_t opt_none();
    opt_t r;
    r.v  = '0;
    r.ok = 1'b0;
    return r;
  endfunction

  function automatic opt_t opt_max(opt_t a, opt_t b);
    opt_t r;
    if (!a.ok) begin
      r = b;
    end else if (!b.ok) begin
      r = a;
    end else begin
      r = some(vmax(a.v, b.v));
    end
    return r;
  endfunction

  function automatic opt_t opt_add(opt_t a, opt_t b);
    opt_t r;
    if (!a.ok || !b.ok) begin
      r = opt_none();
    end else begin
      r = some(sat_add(a.v, b.v));
    end
    return r;
  endfunction

  // A peak counts only where it is strictly above the threshold.
  function automatic opt_t over_thr(val_t s, wm_t thr);
    opt_t r;
    logic above;
    above = !s[ValueWidth-1] &&
            (CmpWidth'(s[ValueWidth-2:0]) > CmpWidth'(thr));
    r = above ? some(s) : opt_none();
    return r;
  endfunction

endpackage

>>> rtl/sp_cc_combine.sv
`timescale 1ns / 1ps

// Series or parallel combination of two summaries, or a pass of the left one
// when both are trivial.
module sp_cc_combine (
  input  sp_cc_pkg::req_t  req_i,
  input  sp_cc_pkg::wm_t   thr_i,
  output sp_cc_pkg::summ_t summ_o
);

  sp_cc_pkg::summ_t a, b, ser, par;
  sp_cc_pkg::opt_t  c1, c2, m1, m2;

  always_comb begin
    a.total     = req_i.left_total;
    a.single    = req_i.left_single;
    a.robust.ok = req_i.left_robust_valid;
    a.robust.v  = req_i.left_robust_valid ? req_i.left_robust : '0;
    a.trivial   = req_i.left_trivial;
    b.total     = req_i.right_total;
    b.single    = req_i.right_single;
    b.robust.ok = req_i.right_robust_valid;
    b.robust.v  = req_i.right_robust_valid ? req_i.right_robust : '0;
    b.trivial   = req_i.right_trivial;
  end

  always_comb begin
    ser.total   = sp_cc_pkg::sat_add(a.total, b.total);
    ser.single  = sp_cc_pkg::vmax(a.single, sp_cc_pkg::sat_add(a.total, b.single));
    ser.robust  = sp_cc_pkg::opt_max(a.robust,
                    sp_cc_pkg::opt_add(b.robust, sp_cc_pkg::some(a.total)));
    ser.trivial = 1'b0;
  end

  always_comb begin
    c1 = sp_cc_pkg::over_thr(a.single, thr_i);
    c2 = sp_cc_pkg::over_thr(b.single, thr_i);
    m1 = sp_cc_pkg::opt_max(sp_cc_pkg::opt_max(c1, a.robust),
           sp_cc_pkg::some(sp_cc_pkg::vmax(a.total, '0)));
    m2 = sp_cc_pkg::opt_max(sp_cc_pkg::opt_max(c2, b.robust),
           sp_cc_pkg::some(sp_cc_pkg::vmax(b.total, '0)));
    par.total   = sp_cc_pkg::sat_add(a.total, b.total);
    par.single  = sp_cc_pkg::vmax(
                    sp_cc_pkg::sat_add(a.single, sp_cc_pkg::vmax('0, b.total)),
                    sp_cc_pkg::sat_add(b.single, sp_cc_pkg::vmax('0, a.total)));
    par.robust  = sp_cc_pkg::opt_max(
                    sp_cc_pkg::opt_max(sp_cc_pkg::opt_add(c1, c2),
                                       sp_cc_pkg::opt_add(m1, b.robust)),
                    sp_cc_pkg::opt_add(m2, a.robust));
    par.trivial = 1'b0;
  end

  always_comb begin
    if (a.trivial && b.trivial) begin
      summ_o = a;
    end else if (req_i.req_type == sp_cc_pkg::ReqParallel) begin
      summ_o = par;
    end else begin
      summ_o = ser;
    end
  end

endmodule

>>> rtl/sp_cc_wmark.sv
`timescale 1ns / 1ps

// Watermark of one summary: the largest of the single peak above threshold,
// the robust peak and zero, clamped to the watermark width.
module sp_cc_wmark (
  input  sp_cc_pkg::summ_t summ_i,
  input  sp_cc_pkg::wm_t   thr_i,
  output sp_cc_pkg::wm_t   wm_o
);

  sp_cc_pkg::opt_t w;
  sp_cc_pkg::cmp_t wext;

  always_comb begin
    w = sp_cc_pkg::opt_max(
          sp_cc_pkg::opt_max(sp_cc_pkg::over_thr(summ_i.single, thr_i), summ_i.robust),
          sp_cc_pkg::some('0));
    // The value is never negative here, so its sign bit can be dropped.
    wext = sp_cc_pkg::CmpWidth'(w.v[sp_cc_pkg::ValueWidth-2:0]);
    if (wext > sp_cc_pkg::CmpWidth'(sp_cc_pkg::WmMax)) begin
      wm_o = sp_cc_pkg::WmMax;
    end else begin
      wm_o = wext[sp_cc_pkg::WmWidth-1:0];
    end
  end

endmodule

>>> rtl/sp_component_combine.sv
`timescale 1ns / 1ps

// Combines a left and a right memory summary, in series or in parallel, and
// returns the combined summary with its watermark. Each input beat carries
// both summaries and the combine type; each accepted beat gives exactly one
// output beat, in order. The block takes one beat per cycle unless stalled
// and never holds state between beats. The path is three registers deep: the
// input register, a middle register that holds the combined summary, and the
// output register that adds the watermark; a beat passes through them in that
// order before out_valid_o shows it. A stall on the output holds a full stage
// in place only when every stage after it is full too, and reaches the
// input only once all three stages hold a beat. All sums saturate to the
// value width.
// The threshold register resets to zero and must only be written while no
// beat is in flight; it takes effect for the next accepted beat.
module sp_component_combine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  sp_cc_pkg::wm_t    cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sp_cc_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sp_cc_pkg::rsp_t   out_data_o
);

  sp_cc_pkg::wm_t   thr_q;
  sp_cc_pkg::req_t  in_q;
  sp_cc_pkg::summ_t mid_q, mid_d;
  sp_cc_pkg::rsp_t  out_q, out_d;
  sp_cc_pkg::wm_t   wm;
  logic             in_v_q, mid_v_q, out_v_q;
  logic             adv_in, adv_mid, adv_out;

  // Each stage moves on when it is empty or when the stage after it moves.
  assign adv_out = !out_v_q || !out_stall_i;
  assign adv_mid = !mid_v_q || adv_out;
  assign adv_in  = !in_v_q  || adv_mid;

  assign in_stall_o  = !adv_in;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_v_q <= in_valid_i;
      end
      if (adv_mid) begin
        mid_v_q <= in_v_q;
      end
      if (adv_out) begin
        out_v_q <= mid_v_q;
      end
    end
  end

  sp_cc_combine u_combine (
    .req_i  (in_q),
    .thr_i  (thr_q),
    .summ_o (mid_d)
  );

  sp_cc_wmark u_wmark (
    .summ_i (mid_q),
    .thr_i  (thr_q),
    .wm_o   (wm)
  );

  always_comb begin
    out_d.out_total        = mid_q.total;
    out_d.out_single       = mid_q.single;
    out_d.out_robust       = mid_q.robust.ok ? mid_q.robust.v : '0;
    out_d.out_robust_valid = mid_q.robust.ok;
    out_d.out_trivial      = mid_q.trivial;
    out_d.watermark        = wm;
  end

  // Payload registers carry no reset; they only load when their stage moves.
  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv_mid && in_v_q) begin
      mid_q <= mid_d;
    end
    if (adv_out && mid_v_q) begin
      out_q <= out_d;
    end
  end

  // A null robust peak always leaves the block as zero.
  a_null_robust_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_robust_valid |-> out_data_o.out_robust == '0)
    else $error("null robust peak with non-zero value");

  // The input side only stalls when every stage holds a beat.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_v_q && mid_v_q && out_v_q)
    else $error("input stalled with an empty stage");

  // A held middle beat keeps its contents until it moves on.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_v_q && !adv_mid |=> mid_v_q && $stable(mid_q))
    else $error("middle stage lost or changed a held beat");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sp_cc_pkg::*;

  // Generous ceiling on the run length, well above the slowest legal run.
  localparam int CycleLimit = 400000;
  localparam int RandPerPhase = 260;

  // Optional value as the predictor sees it: a plain integer plus a
  // presence bit. A null value always carries zero.
  typedef struct {
    longint v;
    bit     ok;
  } maybe_t;

  typedef struct {
    longint total;
    longint single;
    maybe_t robust;
    bit     trivial;
  } mem_sum_t;

  // The scoreboard holds its own copy of the threshold, predicts the
  // combined summary for every accepted input beat and keeps the
  // predictions in arrival order until the matching output beat turns up.
  class combine_scoreboard;
    wm_t    threshold;
    rsp_t   expected_combined[$];
    int     errors;
    int     checked;
    int     n_series;
    int     n_parallel;
    int     n_passed;

    function new();
      threshold = '0;
      errors = 0;
      checked = 0;
      n_series = 0;
      n_parallel = 0;
      n_passed = 0;
    endfunction

    function int pending();
      return expected_combined.size();
    endfunction

    function longint clamp_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > longint'(ValMax)) begin
        s = longint'(ValMax);
      end else if (s < longint'(ValMin)) begin
        s = longint'(ValMin);
      end
      return s;
    endfunction

    function longint larger(longint a, longint b);
      return (a > b) ? a : b;
    endfunction

    function maybe_t just(longint v);
      maybe_t m;
      m.v = v;
      m.ok = 1'b1;
      return m;
    endfunction

    function maybe_t nothing();
      maybe_t m;
      m.v = 0;
      m.ok = 1'b0;
      return m;
    endfunction

    // A null operand makes the whole sum null.
    function maybe_t maybe_add(maybe_t a, maybe_t b);
      if (!a.ok || !b.ok) begin
        return nothing();
      end
      return just(clamp_add(a.v, b.v));
    endfunction

    // A maximum simply skips null operands.
    function maybe_t maybe_max(maybe_t a, maybe_t b);
      if (!a.ok) begin
        return b;
      end
      if (!b.ok) begin
        return a;
      end
      return just(larger(a.v, b.v));
    endfunction

    function maybe_t above_limit(longint s);
      return (s > longint'(threshold)) ? just(s) : nothing();
    endfunction

    function mem_sum_t side(val_t t, val_t s, val_t r, logic rv, logic tr);
      mem_sum_t m;
      m.total = t;
      m.single = s;
      m.robust = rv ? just(r) : nothing();
      m.trivial = tr;
      return m;
    endfunction

    function rsp_t combine_summaries(req_t q);
      mem_sum_t a;
      mem_sum_t b;
      mem_sum_t c;
      maybe_t   c1;
      maybe_t   c2;
      maybe_t   m1;
      maybe_t   m2;
      maybe_t   w;
      rsp_t     r;
      a = side(q.left_total, q.left_single, q.left_robust, q.left_robust_valid,
               q.left_trivial);
      b = side(q.right_total, q.right_single, q.right_robust, q.right_robust_valid,
               q.right_trivial);
      if (a.trivial && b.trivial) begin
        c = a;
        n_passed++;
      end else if (q.req_type == ReqParallel) begin
        c1 = above_limit(a.single);
        c2 = above_limit(b.single);
        c.total = clamp_add(a.total, b.total);
        c.single = larger(clamp_add(a.single, larger(0, b.total)),
                          clamp_add(b.single, larger(0, a.total)));
        m1 = maybe_max(maybe_max(maybe_max(c1, a.robust), just(a.total)), just(0));
        m2 = maybe_max(maybe_max(maybe_max(c2, b.robust), just(b.total)), just(0));
        c.robust = maybe_max(maybe_max(maybe_add(c1, c2), maybe_add(m1, b.robust)),
                             maybe_add(m2, a.robust));
        c.trivial = 1'b0;
        n_parallel++;
      end else begin
        c.total = clamp_add(a.total, b.total);
        c.single = larger(a.single, clamp_add(a.total, b.single));
        c.robust = maybe_max(a.robust, maybe_add(b.robust, just(a.total)));
        c.trivial = 1'b0;
        n_series++;
      end
      w = maybe_max(maybe_max(above_limit(c.single), c.robust), just(0));
      r.out_total = val_t'(c.total);
      r.out_single = val_t'(c.single);
      r.out_robust = c.robust.ok ? val_t'(c.robust.v) : '0;
      r.out_robust_valid = c.robust.ok;
      r.out_trivial = c.trivial;
      r.watermark = (w.v > longint'(WmMax)) ? WmMax : wm_t'(w.v);
      return r;
    endfunction

    task note_request(req_t q);
      expected_combined.push_back(combine_summaries(q));
    endtask

    task report(string msg);
      $display("[%0t] result beat %0d: %s", $time, checked, msg);
      errors++;
    endtask

    task check_field(string name, longint got, longint want);
      if (got != want) begin
        report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_combined.size() == 0) begin
        report("output beat with no input beat waiting for it");
      end else begin
        want = expected_combined.pop_front();
        check_field("out_total", got.out_total, want.out_total);
        check_field("out_single", got.out_single, want.out_single);
        check_field("out_robust", got.out_robust, want.out_robust);
        check_field("out_robust_valid", got.out_robust_valid, want.out_robust_valid);
        check_field("out_trivial", got.out_trivial, want.out_trivial);
        check_field("watermark", got.watermark, want.watermark);
      end
      checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  wm_t  cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;

  combine_scoreboard book = new();
  int cycle_count = 0;
  int thresholds_used = 0;
  int stall_span = 0;
  int stall_mode = 0;

  sp_component_combine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The receiver stalls on a pattern of its own. Every so often it picks a
  // new mode, ranging from never stalling to stalling almost all the time,
  // so that back-pressure lands on every stage of the pipeline and there are
  // also long stretches where the output drains freely.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 96);
      stall_mode <= $urandom_range(0, 4);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 1) == 1);
      end
      3: begin
        out_stall_i <= ($urandom_range(0, 9) != 0);
      end
      default: begin
        out_stall_i <= ((cycle_count % 5) < 2);
      end
    endcase
  end

  // Every output beat taken at this edge is checked against the oldest
  // prediction. The values read here are those from just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.check_result(out_data_o);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Presents one input beat and holds it until the block takes it. Valid
  // is raised at a clock edge and the beat counts as accepted at the first
  // later edge where the stall was low.
  task automatic send_item(input req_t q);
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    book.note_request(q);
  endtask

  // Sends a list of beats in bursts of random length. Between bursts the
  // sender goes quiet for a few cycles; no gap follows the final beat, so
  // that valid is lowered only once by whoever comes next.
  task automatic pump(input req_t beats[$], input bit with_gaps);
    int burst;
    burst = $urandom_range(1, 16);
    foreach (beats[i]) begin
      send_item(beats[i]);
      burst--;
      if (with_gaps && burst == 0 && i != beats.size() - 1) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        burst = $urandom_range(1, 16);
      end
    end
  endtask

  // The threshold may only change with nothing in flight, so the sender
  // goes quiet, every prediction is matched, and the pipeline (three
  // registers deep) gets a few more cycles before the write.
  task automatic set_threshold(input wm_t thr);
    in_valid_i <= 1'b0;
    while (book.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.threshold = thr;
    thresholds_used++;
  endtask

  function automatic req_t make_req(logic kind, val_t lt, val_t ls, val_t lr, logic lrv,
                                    logic ltr, val_t rt, val_t rs, val_t rr, logic rrv,
                                    logic rtr);
    req_t q;
    q.req_type = kind;
    q.left_total = lt;
    q.left_single = ls;
    q.left_robust = lr;
    q.left_robust_valid = lrv;
    q.left_trivial = ltr;
    q.right_total = rt;
    q.right_single = rs;
    q.right_robust = rr;
    q.right_robust_valid = rrv;
    q.right_trivial = rtr;
    return q;
  endfunction

  // Values are drawn from a mix of extremes, tiny numbers, values hugging
  // the current threshold and fully random patterns, so that saturation and
  // the strict threshold comparison are both hit often.
  function automatic val_t pick_value(wm_t thr);
    val_t v;
    case ($urandom_range(0, 9))
      0: v = ValMax;
      1: v = ValMin;
      2: v = '0;
      3: v = val_t'(int'($urandom_range(0, 6)) - 3);
      4: v = val_t'(longint'(thr) + int'($urandom_range(0, 4)) - 2);
      5, 6: v = val_t'(int'($urandom_range(0, 131072)) - 65536);
      default: v = val_t'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  function automatic req_t random_req(wm_t thr);
    return make_req(($urandom_range(0, 1) == 1) ? ReqParallel : ReqSeries,
                    pick_value(thr), pick_value(thr), pick_value(thr),
                    ($urandom_range(0, 1) == 1), ($urandom_range(0, 2) == 0),
                    pick_value(thr), pick_value(thr), pick_value(thr),
                    ($urandom_range(0, 1) == 1), ($urandom_range(0, 2) == 0));
  endfunction

  initial begin
    req_t beats[$];
    wm_t  phase_thr[$];
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with a small threshold so that singles either side
    // of it can be placed by hand.
    set_threshold(wm_t'(100));
    // Both sides trivial: the left summary comes through untouched, and a
    // null left robust peak shows as zero however its field is set.
    beats.push_back(make_req(ReqSeries, 5, 40, 70, 1, 1, 9, 9, 9, 1, 1));
    beats.push_back(make_req(ReqParallel, -3, 200, 55, 0, 1, 1, 1, 1, 1, 1));
    // Only one side trivial still combines normally.
    beats.push_back(make_req(ReqSeries, 7, 12, 3, 1, 1, 2, 30, 4, 1, 0));
    beats.push_back(make_req(ReqParallel, 7, 12, 3, 1, 0, 2, 30, 4, 0, 1));
    beats.push_back(make_req(ReqSeries, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    beats.push_back(make_req(ReqParallel, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Saturation at both ends of the range.
    beats.push_back(make_req(ReqSeries, ValMax, ValMax, ValMax, 1, 0,
                             ValMax, ValMax, ValMax, 1, 0));
    beats.push_back(make_req(ReqSeries, ValMin, ValMin, ValMin, 1, 0,
                             ValMin, ValMin, ValMin, 1, 0));
    beats.push_back(make_req(ReqParallel, ValMax, ValMax, ValMax, 1, 0,
                             ValMax, ValMax, ValMax, 1, 0));
    beats.push_back(make_req(ReqParallel, ValMin, ValMin, ValMin, 1, 0,
                             ValMin, ValMin, ValMin, 1, 0));
    // Null robust peaks on one side, the other, or both.
    beats.push_back(make_req(ReqSeries, 10, 20, 30, 1, 0, 5, 6, 7, 0, 0));
    beats.push_back(make_req(ReqSeries, -10, 20, 30, 0, 0, 5, 6, 7, 1, 0));
    beats.push_back(make_req(ReqParallel, 4, 150, 0, 0, 0, 8, 120, 0, 0, 0));
    // One single exactly at the threshold, the other just above it.
    beats.push_back(make_req(ReqParallel, 4, 100, 0, 0, 0, 8, 101, 0, 0, 0));
    // Everything negative, so the watermark falls back to zero.
    beats.push_back(make_req(ReqSeries, -50, -20, -30, 1, 0, -5, -60, -70, 1, 0));
    beats.push_back(make_req(ReqParallel, 30, 90, 60, 1, 0, -30, 40, 0, 0, 0));
    beats.push_back(make_req(ReqParallel, 0, ValMax, 0, 0, 0, 0, ValMin, 0, 0, 0));
    beats.push_back(make_req(ReqSeries, ValMax, 0, ValMax, 1, 0,
                             ValMin, ValMax, ValMin, 1, 0));
    beats.push_back(make_req(ReqParallel, ValMin, ValMin, ValMin, 1, 0,
                             ValMax, ValMax, ValMax, 1, 0));
    beats.push_back(make_req(ReqParallel, -1, -1, -1, 1, 0, -1, -1, -1, 1, 0));
    pump(beats, 1'b1);

    // Random part over several thresholds, the two extremes among them. One
    // phase runs without sender gaps to keep the pipeline full.
    phase_thr.push_back('0);
    phase_thr.push_back(WmMax);
    phase_thr.push_back(wm_t'($urandom_range(0, 1 << 20)));
    phase_thr.push_back(wm_t'({$urandom, $urandom}));
    phase_thr.push_back(wm_t'(100));
    foreach (phase_thr[p]) begin
      set_threshold(phase_thr[p]);
      beats.delete();
      repeat (RandPerPhase) beats.push_back(random_req(phase_thr[p]));
      pump(beats, p != 2);
    end

    in_valid_i <= 1'b0;
    while (book.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Checked %0d result beats: %0d series, %0d parallel, %0d passed through,",
             book.checked, book.n_series, book.n_parallel, book.n_passed);
    $display("across %0d threshold settings in %0d cycles, %0d mismatches.",
             thresholds_used, cycle_count, book.errors);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sp_cc_pkg.sv
rtl/sp_cc_combine.sv
rtl/sp_cc_wmark.sv
rtl/sp_component_combine.sv
bench/tb_top.sv
